>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the circular range add / min tree.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

>>> src/crat_pkg.sv
// Types, codes and helpers of the circular range add / min tree.
// No dependencies; used by the engine and the top level.
`timescale 1ns / 1ps

package crat_pkg;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   localparam logic [16:0] COUNT_RESET = 17'h10000;
   localparam logic [63:0] MIN_INIT    = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      action_type         action;
      logic [15:0]        left_index;
      logic [15:0]        right_index;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [63:0] min_value;
      logic               status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_VISIT,
      ST_APPLY,
      ST_HD_PEND,
      ST_HD_LEFT,
      ST_HD_RIGHT,
      ST_HD_ZERO,
      ST_RETURN,
      ST_PU_LEFT,
      ST_PU_RIGHT,
      ST_PU_WRITE,
      ST_FINISH
   } eng_state_type;

   function automatic logic [63:0] smin(input logic [63:0] a, input logic [63:0] b);
      return ($signed(a) <= $signed(b)) ? a : b;
   endfunction

endpackage

>>> src/crat_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module crat_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AddrWidth = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/crat_engine.sv
// Tree walker: walks the lazy segment tree held in two RAMs (node minimum,
// pending add). Depends on crat_pkg and crat_ram.
`timescale 1ns / 1ps

module crat_engine #(
   parameter int MAX_ELEMENTS = 65536
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [16:0]      count,
   input  logic             start,
   input  crat_pkg::req_type cmd,
   input  logic             out_free,
   output logic             idle,
   output logic             done,
   output crat_pkg::rsp_type result
);
   import crat_pkg::*;

   localparam int IW    = $clog2(MAX_ELEMENTS);
   localparam int NW    = IW + 1;
   localparam int DEPTH = 2 ** NW;
   localparam int DW    = $clog2(IW + 1);
   localparam int SW    = (IW > 1) ? $clog2(IW) : 1;
   localparam logic [IW-1:0] TOP  = IW'(MAX_ELEMENTS - 1);
   localparam logic [31:0]   MAXW = 32'(MAX_ELEMENTS);
   localparam logic [NW-1:0] ROOT = NW'(1);

   eng_state_type state_ff, state_in;
   req_type       cmd_ff, cmd_in;
   logic [IW-1:0] a_ff, a_in, b_ff, b_in, rb_ff, rb_in, lo_ff, lo_in, hi_ff, hi_in;
   logic          wrap_ff, wrap_in;
   logic [63:0]   v_ff, v_in, dlt_ff, dlt_in, tmp_ff, tmp_in, acc_ff, acc_in;
   logic [NW-1:0] node_ff, node_in, clr_ff, clr_in;
   logic [DW-1:0] d_ff, d_in;
   logic          status_ff, status_in;
   logic [IW-1:0] stk_lo_ff [IW];
   logic [IW-1:0] stk_hi_ff [IW];
   logic          push;

   logic [NW-1:0] rd_addr, min_wa, pend_wa;
   logic          min_we, pend_we;
   logic [63:0]   min_wd, pend_wd, min_rd, pend_rd;

   logic [31:0]   n32, li32, ri32;
   logic          li_bad, ri_bad, covered;
   logic [IW-1:0] last, li_n, ri_n, mid, plo, phi, pmid;
   logic [IW:0]   sum, psum;
   logic [DW-1:0] dm1;
   logic [NW-1:0] left_node, right_node;

   always_comb begin
      n32     = (32'(count) > MAXW) ? MAXW : 32'(count);
      li32    = 32'(cmd_ff.left_index);
      ri32    = 32'(cmd_ff.right_index);
      li_bad  = li32 >= n32;
      ri_bad  = ri32 >= n32;
      last    = IW'(n32 - 32'd1);
      li_n    = IW'(cmd_ff.left_index);
      ri_n    = IW'(cmd_ff.right_index);
      sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
      mid     = sum[IW:1];
      dm1     = d_ff - DW'(1);
      plo     = stk_lo_ff[dm1[SW-1:0]];
      phi     = stk_hi_ff[dm1[SW-1:0]];
      psum    = {1'b0, plo} + {1'b0, phi};
      pmid    = psum[IW:1];
      covered = (lo_ff >= a_ff) && (hi_ff <= b_ff);
      left_node  = {node_ff[NW-2:0], 1'b0};
      right_node = {node_ff[NW-2:0], 1'b1};
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      rb_in     = rb_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      wrap_in   = wrap_ff;
      v_in      = v_ff;
      dlt_in    = dlt_ff;
      tmp_in    = tmp_ff;
      acc_in    = acc_ff;
      node_in   = node_ff;
      clr_in    = clr_ff;
      d_in      = d_ff;
      status_in = status_ff;
      push      = 1'b0;
      idle      = 1'b0;
      done      = 1'b0;
      rd_addr   = node_ff;
      min_we    = 1'b0;
      min_wa    = node_ff;
      min_wd    = '0;
      pend_we   = 1'b0;
      pend_wa   = node_ff;
      pend_wd   = '0;

      case (state_ff)
         ST_CLEAR: begin
            min_we  = 1'b1;
            pend_we = 1'b1;
            min_wa  = clr_ff;
            pend_wa = clr_ff;
            clr_in  = clr_ff + NW'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               cmd_in   = cmd;
               state_in = ST_START;
            end
         end
         ST_START: begin
            acc_in    = MIN_INIT;
            status_in = STATUS_OK;
            wrap_in   = 1'b0;
            v_in      = {{32{cmd_ff.value[31]}}, cmd_ff.value};
            node_in   = ROOT;
            lo_in     = '0;
            hi_in     = TOP;
            d_in      = '0;
            case (cmd_ff.action)
               ACT_WRITE: begin
                  if (li_bad) begin
                     status_in = STATUS_RANGE;
                     state_in  = ST_FINISH;
                  end else begin
                     a_in     = li_n;
                     b_in     = li_n;
                     state_in = ST_VISIT;
                  end
               end
               ACT_ADD, ACT_QUERY: begin
                  if (li_bad || ri_bad) begin
                     status_in = STATUS_RANGE;
                     state_in  = ST_FINISH;
                  end else if (cmd_ff.left_index <= cmd_ff.right_index) begin
                     a_in     = li_n;
                     b_in     = ri_n;
                     state_in = ST_VISIT;
                  end else begin
                     // wrapping range: tail of the array first, then the head
                     a_in     = li_n;
                     b_in     = last;
                     rb_in    = ri_n;
                     wrap_in  = 1'b1;
                     state_in = ST_VISIT;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_VISIT: begin
            state_in = covered ? ST_APPLY : ST_HD_PEND;
         end
         ST_APPLY: begin
            case (cmd_ff.action)
               ACT_QUERY: begin
                  acc_in = smin(acc_ff, min_rd);
               end
               ACT_WRITE: begin
                  min_we  = 1'b1;
                  min_wd  = v_ff;
                  pend_we = 1'b1;
                  pend_wd = '0;
               end
               default: begin
                  min_we  = 1'b1;
                  min_wd  = min_rd + v_ff;
                  pend_we = 1'b1;
                  pend_wd = pend_rd + v_ff;
               end
            endcase
            state_in = ST_RETURN;
         end
         ST_HD_PEND: begin
            dlt_in   = pend_rd;
            rd_addr  = left_node;
            state_in = ST_HD_LEFT;
         end
         ST_HD_LEFT: begin
            min_we   = 1'b1;
            min_wa   = left_node;
            min_wd   = min_rd + dlt_ff;
            pend_we  = 1'b1;
            pend_wa  = left_node;
            pend_wd  = pend_rd + dlt_ff;
            rd_addr  = right_node;
            state_in = ST_HD_RIGHT;
         end
         ST_HD_RIGHT: begin
            min_we   = 1'b1;
            min_wa   = right_node;
            min_wd   = min_rd + dlt_ff;
            pend_we  = 1'b1;
            pend_wa  = right_node;
            pend_wd  = pend_rd + dlt_ff;
            state_in = ST_HD_ZERO;
         end
         ST_HD_ZERO: begin
            pend_we = 1'b1;
            pend_wd = '0;
            push    = 1'b1;
            d_in    = d_ff + DW'(1);
            if (a_ff <= mid) begin
               node_in = left_node;
               hi_in   = mid;
            end else begin
               node_in = right_node;
               lo_in   = mid + IW'(1);
            end
            state_in = ST_VISIT;
         end
         ST_RETURN: begin
            if (d_ff == '0) begin
               if (wrap_ff) begin
                  wrap_in  = 1'b0;
                  a_in     = '0;
                  b_in     = rb_ff;
                  node_in  = ROOT;
                  lo_in    = '0;
                  hi_in    = TOP;
                  state_in = ST_VISIT;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (!node_ff[0] && (b_ff > pmid)) begin
               // back from the left child, range reaches into the right one
               node_in  = {node_ff[NW-1:1], 1'b1};
               lo_in    = pmid + IW'(1);
               hi_in    = phi;
               state_in = ST_VISIT;
            end else begin
               node_in  = {1'b0, node_ff[NW-1:1]};
               lo_in    = plo;
               hi_in    = phi;
               d_in     = dm1;
               state_in = (cmd_ff.action == ACT_QUERY) ? ST_RETURN : ST_PU_LEFT;
            end
         end
         ST_PU_LEFT: begin
            rd_addr  = left_node;
            state_in = ST_PU_RIGHT;
         end
         ST_PU_RIGHT: begin
            tmp_in   = min_rd;
            rd_addr  = right_node;
            state_in = ST_PU_WRITE;
         end
         ST_PU_WRITE: begin
            min_we   = 1'b1;
            min_wd   = smin(tmp_ff, min_rd);
            state_in = ST_RETURN;
         end
         ST_FINISH: begin
            done = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      rb_ff     <= rb_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      wrap_ff   <= wrap_in;
      v_ff      <= v_in;
      dlt_ff    <= dlt_in;
      tmp_ff    <= tmp_in;
      acc_ff    <= acc_in;
      node_ff   <= node_in;
      d_ff      <= d_in;
      status_ff <= status_in;
      if (push) begin
         stk_lo_ff[d_ff[SW-1:0]] <= lo_ff;
         stk_hi_ff[d_ff[SW-1:0]] <= hi_ff;
      end
   end

   assign result.min_value = ((cmd_ff.action == ACT_QUERY) && (status_ff == STATUS_OK))
                             ? acc_ff : '0;
   assign result.status    = status_ff;

   crat_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_min_ram (
      .clock   (clock),
      .wr_en   (min_we),
      .wr_addr (min_wa),
      .wr_data (min_wd),
      .rd_addr (rd_addr),
      .rd_data (min_rd)
   );

   crat_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_we),
      .wr_addr (pend_wa),
      .wr_data (pend_wd),
      .rd_addr (rd_addr),
      .rd_data (pend_rd)
   );

endmodule

>>> src/circular_range_add_min_tree.sv
// Circular range add / range minimum over signed 64-bit elements kept in a
// lazy segment tree of 2*2^ceil(log2(MAX_ELEMENTS)) nodes, stored in two
// RAMs with one write and one read port (node minimum, pending add). After
// reset a clearing pass zeroes both RAMs; req_ready stays low until it ends,
// CSR writes are taken as ever.
// One item at a time: after a setup step, each node passed on the way down is
// visited, its pending add is read, added into both children and cleared; a
// covered node is visited and applied, and each node on the way back up takes a
// return step plus reads of both children and a min write (queries skip the min
// update). A wrapping range makes two passes from the root; both RAMs share one
// read address. A result beat waits in an output register, so the next item is taken while it stalls.
// Depends on crat_pkg, crat_engine, crat_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module circular_range_add_min_tree #(
   parameter int MAX_ELEMENTS = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [15:0]        req_left_index,
   input  logic [15:0]        req_right_index,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_min_value,
   output logic               rsp_status,
   input  logic               csr_write_enable,
   input  logic [16:0]        csr_write_data
);
   import crat_pkg::*;

   logic [16:0] count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   req_type     req;
   rsp_type     eng_result;
   logic        eng_idle, eng_done, out_free, start;

   always_comb begin
      req.action      = action_type'(req_action);
      req.left_index  = req_left_index;
      req.right_index = req_right_index;
      req.value       = req_value;
      start           = req_valid && eng_idle;
      out_free        = !rsp_valid_ff || rsp_ready;
      count_in        = csr_write_enable ? csr_write_data : count_ff;
      rsp_valid_in    = eng_done || (rsp_valid_ff && !rsp_ready);
      rsp_in          = eng_done ? eng_result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   crat_engine #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_engine (
      .clock    (clock),
      .reset    (reset),
      .count    (count_ff),
      .start    (start),
      .cmd      (req),
      .out_free (out_free),
      .idle     (eng_idle),
      .done     (eng_done),
      .result   (eng_result)
   );

   assign req_ready     = eng_idle;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_value = rsp_ff.min_value;
   assign rsp_status    = rsp_ff.status;

   // a finished item must never overwrite a beat still waiting downstream
   `ASSERT_NEVER(a_no_overwrite, clock, reset, eng_done && rsp_valid_ff && !rsp_ready, "beat lost")
   `ASSERT_NEVER(a_done_busy, clock, reset, eng_done && req_ready, "idle while finishing")
   `ASSERT_HOLDS(a_one_item, clock, reset, (req_valid && req_ready) |=> !req_ready, "taken while busy")

endmodule
